// ===== src/rc_armed_differential_drive_mixer_assert.svh =====
// Assertion macros for the mixer's checker file.
`ifndef RC_ARMED_DIFFERENTIAL_DRIVE_MIXER_ASSERT_SVH
`define RC_ARMED_DIFFERENTIAL_DRIVE_MIXER_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define RCDM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define RCDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define RCDM_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rcdm_pkg.sv =====
// Types, constants and the curve table generator for the drive mixer.
package rcdm_pkg;

  // Field widths
  localparam int CH_W    = 16;
  localparam int STICK_W = 11;
  localparam int OFF_W   = 12;
  localparam int ARG_W   = 14;
  localparam int DRIVE_W = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Curve scale default
  localparam int CURVE_SCALE_DEF = 1000;

  // Stick limits and register reset values
  localparam logic [CH_W-1:0]    STICK_LOW   = 16'd1000;
  localparam logic [CH_W-1:0]    STICK_HIGH  = 16'd2000;
  localparam logic [STICK_W-1:0] CENTER_RST  = 11'd1500;
  localparam logic [CH_W-1:0]    SWITCH_RST  = 16'd2000;
  localparam logic [CH_W-1:0]    LINK_RST    = 16'd1;

  // Drive saturation limits
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 12'sd2047;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -12'sd2048;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STICK_CENTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_CODE    = 2'd2;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Q60 fixed point constants
  localparam logic [63:0] Q_ONE     = 64'h1000_0000_0000_0000;
  localparam logic [63:0] ALPHA_Q60 = 64'd1268213655067531674;

  // Classified frame handed from front to back
  typedef struct packed {
    logic                    armed;
    logic                    thr_pos;
    logic                    arg_neg;
    logic signed [OFF_W-1:0] steer_off;
  } rcdm_ctl_t;

  // Q60 product, keeping bits 123..60
  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Restoring unsigned division, evaluated at elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, b}) begin
        r = r - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Taylor series of sine or cosine with truncation at each term
  function automatic logic [63:0] series(input logic [63:0] x2, input logic [63:0] first,
                                         input logic [63:0] n0);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] nn;
    logic [63:0] k;
    logic        neg;
    int          g;
    term = first;
    sum  = first;
    nn   = n0;
    neg  = 1'b1;
    g    = 0;
    while (g < 40 && term != 64'd0) begin
      k    = (nn + 64'd1) * (nn + 64'd2);
      term = udiv64(qmul(term, x2), k);
      nn   = nn + 64'd2;
      sum  = neg ? sum - term : sum + term;
      neg  = !neg;
      g++;
    end
    return sum;
  endfunction

  // One entry of the tan-shaped curve: scale*tan(1.1*v/scale)/tan(1.1), truncated
  function automatic logic [31:0] curve_pos(input int v, input int scale);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] a2;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] qv;
    logic [63:0] rv;
    logic [63:0] vv;
    logic [63:0] sc;
    logic [63:0] aq;
    if (v == 0) return 32'd0;
    vv  = (v > scale) ? 64'(scale) : 64'(v);
    sc  = 64'(scale);
    aq  = udiv64(ALPHA_Q60, sc);
    x   = aq * vv + udiv64((ALPHA_Q60 - aq * sc) * vv, sc);
    x2  = qmul(x, x);
    a2  = qmul(ALPHA_Q60, ALPHA_Q60);
    num = qmul(series(x2, x, 64'd1), series(a2, Q_ONE, 64'd0));
    den = qmul(series(x2, Q_ONE, 64'd0), series(a2, ALPHA_Q60, 64'd1));
    if (den == 64'd0) return 32'd0;
    qv = '0;
    rv = '0;
    for (int b = 15; b >= 0; b--) begin
      qv = qv << 1;
      rv = rv << 1;
      if (rv >= den) begin
        rv = rv - den;
        qv = qv + 64'd1;
      end
      if (sc[b]) begin
        rv = rv + num;
        if (rv >= den) begin
          rv = rv - den;
          qv = qv + 64'd1;
        end
        if (rv >= den) begin
          rv = rv - den;
          qv = qv + 64'd1;
        end
      end
    end
    if (qv > sc) qv = sc;
    return qv[31:0];
  endfunction

endpackage

// ===== src/rcdm_if.sv =====
// Channel interfaces: frame input, drive result and configuration write.
interface rcdm_in_if
  import rcdm_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            link_ok;
  logic [CH_W-1:0] mode_channel;
  logic [CH_W-1:0] steer_channel;
  logic [CH_W-1:0] throttle_channel;
  logic [CH_W-1:0] switch_a;
  logic [CH_W-1:0] switch_b;

  modport source (output valid, link_ok, mode_channel, steer_channel, throttle_channel,
                  switch_a, switch_b, input ready);
  modport sink (input valid, link_ok, mode_channel, steer_channel, throttle_channel,
                switch_a, switch_b, output ready);
endinterface

interface rcdm_out_if
  import rcdm_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_first;
  logic signed [DRIVE_W-1:0] drive_second;
  logic                      armed;

  modport source (output valid, drive_first, drive_second, armed, input ready);
  modport sink (input valid, drive_first, drive_second, armed, output ready);
endinterface

interface rcdm_cfg_if
  import rcdm_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/rc_armed_differential_drive_mixer.sv =====
// A frame accepted at the input is written into the queue, then passes through
// the registered curve table read and the output register. Throughput: one
// frame per cycle while the output is not stalled; a two-entry queue decouples front and back.
// Reset (rst_n low, synchronous): disarms, loads register defaults
// (center 1500, switch level 2000, link code 1) and empties queue and pipeline.
module rc_armed_differential_drive_mixer
  import rcdm_pkg::*;
#(
  parameter int CURVE_SCALE = CURVE_SCALE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rcdm_in_if.sink    in_chan,
  rcdm_out_if.source out_chan,
  rcdm_cfg_if.sink   cfg_chan
);

  localparam int IW = $clog2(CURVE_SCALE + 1);

  logic          fq_valid;
  logic          fq_ready;
  rcdm_ctl_t     fq_ctl;
  logic [IW-1:0] fq_idx;
  logic          qb_valid;
  logic          qb_ready;
  rcdm_ctl_t     qb_ctl;
  logic [IW-1:0] qb_idx;

  // Classify frames and track arming
  rcdm_front #(
    .CURVE_SCALE(CURVE_SCALE),
    .IW         (IW)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .cfg_chan(cfg_chan),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_ctl   (fq_ctl),
    .q_idx   (fq_idx)
  );

  // Decouple front and back
  rcdm_queue #(
    .IW(IW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_ctl  (fq_ctl),
    .push_idx  (fq_idx),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_ctl   (qb_ctl),
    .pop_idx   (qb_idx)
  );

  // Curve lookup and mixing
  rcdm_back #(
    .CURVE_SCALE(CURVE_SCALE),
    .IW         (IW)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (qb_valid),
    .q_ready (qb_ready),
    .q_ctl   (qb_ctl),
    .q_idx   (qb_idx),
    .out_chan(out_chan)
  );

endmodule

// ===== src/rcdm_front.sv =====
// Front end: configuration registers, arming logic and stick classification.
module rcdm_front
  import rcdm_pkg::*;
#(
  parameter int CURVE_SCALE = CURVE_SCALE_DEF,
  parameter int IW          = $clog2(CURVE_SCALE + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  rcdm_in_if.sink       in_chan,
  rcdm_cfg_if.sink      cfg_chan,
  output logic          q_valid,
  input  logic          q_ready,
  output rcdm_ctl_t     q_ctl,
  output logic [IW-1:0] q_idx
);

  localparam logic signed [ARG_W-1:0] SCALE_S = ARG_W'(CURVE_SCALE);

  logic [STICK_W-1:0]       stick_center_r;
  logic [CH_W-1:0]          switch_level_r;
  logic [CH_W-1:0]          link_code_r;
  logic                     armed_r;
  logic                     armed_nxt;
  logic                     in_xfer;
  logic                     sw_ok;
  logic [STICK_W-1:0]       steer_sat;
  logic [STICK_W-1:0]       thr_sat;
  logic signed [OFF_W-1:0]  steer_off;
  logic signed [OFF_W-1:0]  thr_off;
  logic signed [ARG_W-1:0]  arg_raw;
  logic signed [ARG_W-1:0]  arg_clip;
  logic [ARG_W-1:0]         arg_mag;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = q_ready;
  assign in_xfer        = in_chan.valid && q_ready;

  // Hold configuration; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stick_center_r <= CENTER_RST;
      switch_level_r <= SWITCH_RST;
      link_code_r    <= LINK_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_STICK_CENTER: stick_center_r <= cfg_chan.data[STICK_W-1:0];
        CFG_SWITCH_LEVEL: switch_level_r <= cfg_chan.data;
        CFG_LINK_CODE:    link_code_r    <= cfg_chan.data;
        default:          ;
      endcase
    end
  end

  // Arm needs both switches, staying armed needs either
  always_comb begin
    if (armed_r) begin
      sw_ok = (in_chan.switch_a == switch_level_r) || (in_chan.switch_b == switch_level_r);
    end else begin
      sw_ok = (in_chan.switch_a == switch_level_r) && (in_chan.switch_b == switch_level_r);
    end
    armed_nxt = in_chan.link_ok && sw_ok && (in_chan.mode_channel == link_code_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
    end else if (in_xfer) begin
      armed_r <= armed_nxt;
    end
  end

  // Saturate sticks and take offsets from center
  always_comb begin
    priority if (in_chan.steer_channel < STICK_LOW) begin
      steer_sat = STICK_LOW[STICK_W-1:0];
    end else if (in_chan.steer_channel > STICK_HIGH) begin
      steer_sat = STICK_HIGH[STICK_W-1:0];
    end else begin
      steer_sat = in_chan.steer_channel[STICK_W-1:0];
    end
    priority if (in_chan.throttle_channel < STICK_LOW) begin
      thr_sat = STICK_LOW[STICK_W-1:0];
    end else if (in_chan.throttle_channel > STICK_HIGH) begin
      thr_sat = STICK_HIGH[STICK_W-1:0];
    end else begin
      thr_sat = in_chan.throttle_channel[STICK_W-1:0];
    end
    steer_off = $signed({1'b0, steer_sat}) - $signed({1'b0, stick_center_r});
    thr_off   = $signed({1'b0, thr_sat}) - $signed({1'b0, stick_center_r});
  end

  // Double the throttle offset and clamp it to the curve range
  always_comb begin
    arg_raw = {{(ARG_W-OFF_W-1){thr_off[OFF_W-1]}}, thr_off, 1'b0};
    priority if (arg_raw > SCALE_S) begin
      arg_clip = SCALE_S;
    end else if (arg_raw < -SCALE_S) begin
      arg_clip = -SCALE_S;
    end else begin
      arg_clip = arg_raw;
    end
    arg_mag = arg_clip[ARG_W-1] ? ARG_W'(-arg_clip) : ARG_W'(arg_clip);
  end

  assign q_valid           = in_chan.valid;
  assign q_ctl.armed       = armed_nxt;
  assign q_ctl.thr_pos     = (thr_off > 0);
  assign q_ctl.arg_neg     = arg_clip[ARG_W-1];
  assign q_ctl.steer_off   = steer_off;
  assign q_idx             = arg_mag[IW-1:0];

endmodule

// ===== src/rcdm_queue.sv =====
// Short queue of classified frames between front and back.
module rcdm_queue
  import rcdm_pkg::*;
#(
  parameter int IW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  rcdm_ctl_t     push_ctl,
  input  logic [IW-1:0] push_idx,
  output logic          pop_valid,
  input  logic          pop_ready,
  output rcdm_ctl_t     pop_ctl,
  output logic [IW-1:0] pop_idx
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  rcdm_ctl_t     ctl_q   [QUEUE_DEPTH];
  logic [IW-1:0] idx_q   [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          push;
  logic          pop;

  assign push_ready = (count_r != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_ctl    = ctl_q[rd_ptr_r];
  assign pop_idx    = idx_q[rd_ptr_r];

  // Store an entry on each push transfer
  always_ff @(posedge clk) begin
    if (push) begin
      ctl_q[wr_ptr_r] <= push_ctl;
      idx_q[wr_ptr_r] <= push_idx;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== src/rcdm_back.sv =====
// Back end: curve table lookup, steering mix and output register.
module rcdm_back
  import rcdm_pkg::*;
#(
  parameter int CURVE_SCALE = CURVE_SCALE_DEF,
  parameter int IW          = $clog2(CURVE_SCALE + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  rcdm_ctl_t     q_ctl,
  input  logic [IW-1:0] q_idx,
  rcdm_out_if.source    out_chan
);

  localparam int SUM_W = (IW + 3 > OFF_W + 2) ? IW + 3 : OFF_W + 2;

  logic [IW-1:0]             curve_rom [0:CURVE_SCALE];
  logic                      v1_r;
  rcdm_ctl_t                 ctl1_r;
  logic [IW-1:0]             rom_q_r;
  logic                      out_valid_r;
  logic signed [DRIVE_W-1:0] drive_first_r;
  logic signed [DRIVE_W-1:0] drive_second_r;
  logic                      armed_r;
  logic                      load1;
  logic                      adv2;
  logic signed [SUM_W-1:0]   c_val;
  logic signed [SUM_W-1:0]   s_val;
  logic signed [SUM_W-1:0]   d0;
  logic signed [SUM_W-1:0]   d1;
  logic signed [DRIVE_W-1:0] drive_first_nxt;
  logic signed [DRIVE_W-1:0] drive_second_nxt;

  // Halve, truncating toward zero
  function automatic logic signed [SUM_W-1:0] half_tz(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] adj;
    adj = v + SUM_W'(v[SUM_W-1]);
    return adj >>> 1;
  endfunction

  // Clamp to the drive range
  function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [SUM_W-1:0] v);
    logic signed [DRIVE_W-1:0] r;
    priority if (v > SUM_W'(DRIVE_MAX)) begin
      r = DRIVE_MAX;
    end else if (v < SUM_W'(DRIVE_MIN)) begin
      r = DRIVE_MIN;
    end else begin
      r = v[DRIVE_W-1:0];
    end
    return r;
  endfunction

  // Curve table, built at elaboration
  for (genvar g = 0; g <= CURVE_SCALE; g++) begin : g_rom
    localparam logic [31:0] ENTRY = curve_pos(g, CURVE_SCALE);
    assign curve_rom[g] = ENTRY[IW-1:0];
  end

  assign adv2    = !out_valid_r || out_chan.ready;
  assign load1   = !v1_r || adv2;
  assign q_ready = load1;

  // Stage 1: registered table read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (load1) begin
      v1_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load1 && q_valid) begin
      ctl1_r  <= q_ctl;
      rom_q_r <= curve_rom[q_idx];
    end
  end

  // Mix half of the steering into one side
  always_comb begin
    c_val = ctl1_r.arg_neg ? -$signed({{(SUM_W-IW){1'b0}}, rom_q_r})
                           : $signed({{(SUM_W-IW){1'b0}}, rom_q_r});
    s_val = SUM_W'(ctl1_r.steer_off);
    if (s_val > 0) begin
      d0 = c_val;
      d1 = ctl1_r.thr_pos ? half_tz((c_val <<< 1) - s_val) : half_tz((c_val <<< 1) + s_val);
    end else begin
      d0 = ctl1_r.thr_pos ? half_tz((c_val <<< 1) + s_val) : half_tz((c_val <<< 1) - s_val);
      d1 = c_val;
    end
    if (ctl1_r.armed) begin
      drive_first_nxt  = sat_drive(d0);
      drive_second_nxt = sat_drive(d1);
    end else begin
      drive_first_nxt  = '0;
      drive_second_nxt = '0;
    end
  end

  // Stage 2: output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv2) begin
      out_valid_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      drive_first_r  <= drive_first_nxt;
      drive_second_r <= drive_second_nxt;
      armed_r        <= ctl1_r.armed;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.drive_first  = drive_first_r;
  assign out_chan.drive_second = drive_second_r;
  assign out_chan.armed        = armed_r;

endmodule

// ===== src/rcdm_checker.sv =====
// Port-level checks for the drive mixer, bound to the top level.
`include "rc_armed_differential_drive_mixer_assert.svh"

module rcdm_checker
  import rcdm_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [DRIVE_W-1:0] drive_first,
  input logic signed [DRIVE_W-1:0] drive_second,
  input logic                      armed
);

  // A stalled result holds
  `RCDM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive_first) && $stable(drive_second) && $stable(armed), "result changed while stalled")

  // Disarmed results carry zero drive
  `RCDM_ASSERT_NOW(a_disarmed_zero, out_valid && !armed, drive_first == 0 && drive_second == 0, "nonzero drive while disarmed")

  // Reset empties the output stage
  `RCDM_ASSERT_ALWAYS(a_reset_empty, !rst_n, !out_valid, "result valid after reset")

endmodule

bind rc_armed_differential_drive_mixer rcdm_checker u_rcdm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .drive_first (out_chan.drive_first),
  .drive_second(out_chan.drive_second),
  .armed       (out_chan.armed)
);
